[sv/btb_pkg.sv]
// Shared types, constants and functions for the two-bit branch target buffer.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package btb_pkg;

    localparam int ENTRIES    = 32;
    localparam int ADDR_WIDTH = 16;
    localparam int COUNT_W    = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_PREDICT = 2'd1,
        ACT_UPDATE  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        PS_SNT = 2'd0,
        PS_WNT = 2'd1,
        PS_WT  = 2'd2,
        PS_ST  = 2'd3
    } t_pstate;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EXEC
    } t_ctrl_state;

    typedef struct packed {
        logic                  action_load;
        logic                  lookup;
        logic                  exec;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [1:0]            action;
        logic [ADDR_WIDTH-1:0] pc;
        logic [ADDR_WIDTH-1:0] target;
        logic                  correct;
    } t_req;

    typedef struct packed {
        logic                  predict_taken;
        logic [ADDR_WIDTH-1:0] predicted_target;
        logic                  entry_found;
        logic                  insert_dropped;
        logic [COUNT_W-1:0]    correct_count;
    } t_result;

    // A weak state that proves wrong jumps to the opposite strong state.
    function automatic t_pstate pstate_next(input t_pstate cur, input logic ok);
        t_pstate nxt;
        case (cur)
            PS_ST:   nxt = ok ? PS_ST  : PS_WT;
            PS_WT:   nxt = ok ? PS_ST  : PS_SNT;
            PS_WNT:  nxt = ok ? PS_SNT : PS_ST;
            default: nxt = ok ? PS_SNT : PS_WNT;
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

[sv/btb_ctrl.sv]
// Controller state machine for the branch target buffer.
// Depends on btb_pkg; drives the command struct into btb_dp.
`default_nettype none

module btb_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    output logic                o_busy,
    output btb_pkg::t_ctrl_cmd  o_cmd
);
    import btb_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy            = 1'b1;
        o_cmd.action_load = 1'b0;
        o_cmd.lookup      = 1'b0;
        o_cmd.exec        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy            = 1'b0;
                o_cmd.action_load = i_start;
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/btb_dp.sv]
// Datapath of the branch target buffer: entry table, tag compare, state update.
// Depends on btb_pkg; sequenced by the command struct from btb_ctrl.
`default_nettype none

module btb_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  btb_pkg::t_ctrl_cmd  i_cmd,
    input  btb_pkg::t_req       i_req,
    output logic                o_valid,
    output btb_pkg::t_result    o_result
);
    import btb_pkg::*;

    logic [ENTRIES-1:0]    r_valid;
    logic [ADDR_WIDTH-1:0] r_tag [ENTRIES];
    logic [ADDR_WIDTH-1:0] r_tgt [ENTRIES];
    t_pstate               r_pst [ENTRIES];
    logic [CNT_W-1:0]      r_fill;
    logic [COUNT_W-1:0]    r_count;
    t_req                  r_req;
    logic                  r_hit;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_done;
    t_result               r_res;

    logic [ENTRIES-1:0]    match;
    logic                  n_hit;
    logic [IDX_W-1:0]      n_idx;
    logic                  full;
    logic                  do_ins;
    logic                  do_upd;
    t_pstate               cur_pst;
    logic [COUNT_W-1:0]    n_count;
    t_result               n_res;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_tag[i] == r_req.pc);
        end
    end

    always_comb begin
        n_hit = |match;
        n_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                n_idx = IDX_W'(i);
            end
        end
    end

    assign full    = (r_fill >= CNT_W'(ENTRIES));
    assign cur_pst = r_pst[r_idx];

    always_comb begin
        do_ins  = 1'b0;
        do_upd  = 1'b0;
        n_count = r_count;
        n_res   = '0;
        n_res.entry_found = r_hit;
        case (r_req.action)
            ACT_INSERT: begin
                if (!r_hit) begin
                    if (full) begin
                        n_res.insert_dropped = 1'b1;
                    end else begin
                        do_ins = 1'b1;
                    end
                end
            end
            ACT_PREDICT: begin
                if (r_hit && (cur_pst == PS_ST || cur_pst == PS_WT)) begin
                    n_res.predict_taken    = 1'b1;
                    n_res.predicted_target = r_tgt[r_idx];
                end
            end
            ACT_UPDATE: begin
                if (r_hit) begin
                    do_upd = 1'b1;
                    if (r_req.correct) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                end
            end
            default: begin
                do_ins = 1'b0;
            end
        endcase
        n_res.correct_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_count <= n_count;
                if (do_ins) begin
                    r_valid[r_fill[IDX_W-1:0]] <= 1'b1;
                    r_fill                     <= r_fill + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.action_load) begin
            r_req <= i_req;
        end
        if (i_cmd.lookup) begin
            r_hit <= n_hit;
            r_idx <= n_idx;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
            if (do_ins) begin
                r_tag[r_fill[IDX_W-1:0]] <= r_req.pc;
                r_tgt[r_fill[IDX_W-1:0]] <= r_req.target;
                r_pst[r_fill[IDX_W-1:0]] <= PS_WNT;
            end
            if (do_upd) begin
                r_pst[r_idx] <= pstate_next(cur_pst, r_req.correct);
            end
        end
    end

    assign o_valid  = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

[sv/btb_two_bit_predictor.sv]
// Top level of the two-bit branch target buffer: controller plus datapath.
// Depends on btb_pkg, btb_ctrl and btb_dp.
// The request is registered on acceptance, the tag compare in the lookup state and the result in the execute state.
// A new request is taken only once the controller has passed its
// lookup state (registered tag compare) and its execute state and returned to idle.
// Results cannot be stalled; o_valid is high for exactly one cycle.
// Synchronous active-low reset clears the valid bits, fill count and counter.
`default_nettype none

module btb_two_bit_predictor (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  btb_pkg::t_req     i_req,
    output logic              o_valid,
    output btb_pkg::t_result  o_result
);
    import btb_pkg::*;

    t_ctrl_cmd cmd;

    btb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    btb_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

[sv/btb_checker.sv]
// Port-level checker for the two-bit branch target buffer, bound to the top.
// Depends on btb_pkg and watches only the top level's ports.
`default_nettype none

module btb_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    input  wire               busy,
    input  btb_pkg::t_req     i_req,
    input  wire               o_valid,
    input  btb_pkg::t_result  o_result
);
    import btb_pkg::*;

    logic accepted;
    assign accepted = start && !busy;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accepted |=> busy)
        else $error("busy did not rise after an accepted request");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accepted |-> ##3 o_valid)
        else $error("result did not appear three cycles after the request");

    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while the block is busy");

    a_miss_no_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.entry_found) |->
            (!o_result.predict_taken && o_result.predicted_target == '0))
        else $error("prediction reported without a matching entry");

    a_drop_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.insert_dropped) |-> !o_result.entry_found)
        else $error("insert dropped although the entry was present");

endmodule

bind btb_two_bit_predictor btb_checker u_btb_checker (.*);

`default_nettype wire

[test/btb_two_bit_predictor_test.sv]
// Self-checking testbench for the two-bit branch target buffer.
// It holds its own model of the table, its states and its correct-count, and compares every
// result of the block. Depends on btb_pkg and btb_two_bit_predictor.
`timescale 1ns / 100ps

module btb_two_bit_predictor_test;

    import btb_pkg::*;

    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int         RANDOM_REQS  = 1250;
    localparam int         POOL_SIZE    = 40;
    localparam int         CYCLE_LIMIT  = 400000;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_req    i_req   = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    btb_two_bit_predictor dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Model of the table.
    logic                  tbl_valid  [ENTRIES];
    logic [ADDR_WIDTH-1:0] tbl_tag    [ENTRIES];
    logic [ADDR_WIDTH-1:0] tbl_target [ENTRIES];
    t_pstate               tbl_state  [ENTRIES];
    int                    tbl_fill = 0;
    logic [COUNT_W-1:0]    tbl_hits = '0;

    t_req                  pending_q[$];
    t_result               outcome_q[$];
    logic [ADDR_WIDTH-1:0] pc_pool[POOL_SIZE];

    int gap_left   = 0;
    int calm_left  = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_taken    = 0;
    int n_dropped  = 0;
    int n_good     = 0;
    int n_reserved = 0;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
        end
    end

    function automatic t_result btb_apply(input t_req req);
        t_result res;
        int      hit;
        hit = -1;
        res = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_tag[i] == req.pc) hit = i;
        end
        case (req.action)
            ACT_INSERT: begin
                if (hit < 0) begin
                    if (tbl_fill < ENTRIES) begin
                        tbl_valid[tbl_fill]  = 1'b1;
                        tbl_tag[tbl_fill]    = req.pc;
                        tbl_target[tbl_fill] = req.target;
                        tbl_state[tbl_fill]  = PS_WNT;
                        tbl_fill++;
                    end else begin
                        res.insert_dropped = 1'b1;
                        n_dropped++;
                    end
                end
            end
            ACT_PREDICT: begin
                if (hit >= 0 && (tbl_state[hit] == PS_ST || tbl_state[hit] == PS_WT)) begin
                    res.predict_taken    = 1'b1;
                    res.predicted_target = tbl_target[hit];
                    n_taken++;
                end
            end
            ACT_UPDATE: begin
                if (hit >= 0) begin
                    // A weak state that proves wrong flips to the opposite strong state.
                    case (tbl_state[hit])
                        PS_ST:   tbl_state[hit] = req.correct ? PS_ST : PS_WT;
                        PS_WT:   tbl_state[hit] = req.correct ? PS_ST : PS_SNT;
                        PS_WNT:  tbl_state[hit] = req.correct ? PS_SNT : PS_ST;
                        default: tbl_state[hit] = req.correct ? PS_SNT : PS_WNT;
                    endcase
                    if (req.correct) begin
                        tbl_hits = tbl_hits + 1'b1;
                        n_good++;
                    end
                end
            end
            default: n_reserved++;
        endcase
        res.entry_found   = (hit >= 0);
        res.correct_count = tbl_hits;
        return res;
    endfunction

    task automatic add_req(input logic [1:0] action, input logic [ADDR_WIDTH-1:0] pc,
                           input logic [ADDR_WIDTH-1:0] target, input logic correct);
        t_req req;
        req.action  = action;
        req.pc      = pc;
        req.target  = target;
        req.correct = correct;
        pending_q.push_back(req);
    endtask

    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 5);
        return $urandom_range(6, 30);
    endfunction

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                outcome_q.push_back(btb_apply(i_req));
                n_accepted++;
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    i_req    <= pending_q.pop_front();
                    start    <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result expr;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (outcome_q.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                expr = outcome_q.pop_front();
                check_field("predict_taken", 32'(expr.predict_taken),
                            32'(o_result.predict_taken));
                check_field("predicted_target", 32'(expr.predicted_target),
                            32'(o_result.predicted_target));
                check_field("entry_found", 32'(expr.entry_found),
                            32'(o_result.entry_found));
                check_field("insert_dropped", 32'(expr.insert_dropped),
                            32'(o_result.insert_dropped));
                check_field("correct_count", expr.correct_count, o_result.correct_count);
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int          r;
        logic [1:0]  act;
        logic [ADDR_WIDTH-1:0] pc;

        pc_pool[0] = '0;
        pc_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) pc_pool[i] = ADDR_WIDTH'($urandom);

        // Directed: empty table, duplicates, every state transition, the reserved code.
        add_req(ACT_PREDICT,  16'h0000, 16'h0000, 1'b0);
        add_req(ACT_UPDATE,   16'h0000, 16'h0000, 1'b1);
        add_req(ACT_RESERVED, 16'h0000, 16'hffff, 1'b1);
        add_req(ACT_INSERT,   16'h0000, 16'hffff, 1'b0);
        add_req(ACT_INSERT,   16'hffff, 16'h0000, 1'b1);
        add_req(ACT_INSERT,   16'h0000, 16'h1234, 1'b0);
        add_req(ACT_PREDICT,  16'h0000, 16'h0000, 1'b0);
        add_req(ACT_UPDATE,   16'h0000, 16'h0000, 1'b0);
        add_req(ACT_PREDICT,  16'h0000, 16'h0000, 1'b0);
        add_req(ACT_UPDATE,   16'h0000, 16'h0000, 1'b1);
        add_req(ACT_UPDATE,   16'h0000, 16'h0000, 1'b0);
        add_req(ACT_PREDICT,  16'h0000, 16'h0000, 1'b0);
        add_req(ACT_UPDATE,   16'h0000, 16'h0000, 1'b1);
        add_req(ACT_UPDATE,   16'h0000, 16'h0000, 1'b0);
        add_req(ACT_UPDATE,   16'h0000, 16'h0000, 1'b0);
        add_req(ACT_PREDICT,  16'h0000, 16'h0000, 1'b0);
        add_req(ACT_UPDATE,   16'h0000, 16'h0000, 1'b0);
        add_req(ACT_UPDATE,   16'h0000, 16'h0000, 1'b1);
        add_req(ACT_UPDATE,   16'h0000, 16'h0000, 1'b1);
        add_req(ACT_UPDATE,   16'hffff, 16'hffff, 1'b1);
        add_req(ACT_RESERVED, 16'hffff, 16'h0000, 1'b0);
        add_req(ACT_PREDICT,  16'hffff, 16'hffff, 1'b1);

        // Random: the table fills early, then most traffic hits known branches.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            r = $urandom_range(0, 99);
            if (r < ((n < 150) ? 35 : 8))   act = ACT_INSERT;
            else if (r < 55)                act = ACT_PREDICT;
            else if (r < 97)                act = ACT_UPDATE;
            else                            act = ACT_RESERVED;
            if ($urandom_range(0, 9) == 0) pc = ADDR_WIDTH'($urandom);
            else                           pc = pc_pool[$urandom_range(0, POOL_SIZE - 1)];
            add_req(act, pc, ADDR_WIDTH'($urandom), 1'($urandom_range(0, 1)));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || start || outcome_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (outcome_q.size() != 0) begin
            $error("%0d results never arrived", outcome_q.size());
            n_errors++;
        end
        $display("Ran %0d requests, checked %0d results, table filled to %0d entries.",
                 n_accepted, n_results, tbl_fill);
        $display("Saw %0d taken predictions, %0d dropped inserts, %0d correct updates.",
                 n_taken, n_dropped, n_good);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
